[design/gfd_pkg.sv]
package gfd_pkg;

    // Header byte that opens every frame, twice in a row
    localparam logic [7:0]  HdrByte = 8'hFF;
    // Bias added to rate and angle to form the checksum
    localparam logic [15:0] SumBias = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_SUM_ERR = 2'd1,
        STATUS_HDR_ERR = 2'd2
    } status_t;

    // Framing state: hunting, or the position of the next byte in the frame
    typedef enum logic [3:0] {
        ST_HUNT,
        ST_HDR0,
        ST_HDR1,
        ST_RATE_LO,
        ST_RATE_HI,
        ST_ANGLE_LO,
        ST_ANGLE_HI,
        ST_SUM_LO,
        ST_SUM_HI
    } frame_state_t;

    typedef struct packed {
        logic signed [15:0] turn_rate;
        logic signed [15:0] heading;
        status_t            frame_status;
    } result_t;

endpackage

[design/gfd_byte_if.sv]
interface gfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/gfd_result_if.sv]
interface gfd_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] turn_rate;
    logic signed [15:0] heading;
    logic        [1:0]  frame_status;

    modport source (output valid, output turn_rate, output heading, output frame_status,
                    input ready);
    modport sink   (input valid, input turn_rate, input heading, input frame_status,
                    output ready);
endinterface

[design/gfd_decode.sv]
module gfd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             emit,
    output gfd_pkg::result_t result
);

    gfd_pkg::frame_state_t state_reg;
    gfd_pkg::frame_state_t state_next;
    logic                  prev_ff_reg;
    logic                  prev_ff_next;
    logic [15:0]           rate_reg;
    logic [15:0]           angle_reg;
    logic [7:0]            sum_lo_reg;

    logic                  is_ff;
    logic [15:0]           sum_expect;
    logic [15:0]           sum_got;

    assign is_ff      = (rx_byte == gfd_pkg::HdrByte);
    assign sum_expect = gfd_pkg::SumBias + rate_reg + angle_reg;
    assign sum_got    = {rx_byte, sum_lo_reg};

    // Next framing state
    always_comb
    begin
        state_next   = state_reg;
        prev_ff_next = 1'b0;
        unique case (state_reg)
            gfd_pkg::ST_HUNT:
            begin
                prev_ff_next = is_ff && !prev_ff_reg;
                if (is_ff && prev_ff_reg)
                begin
                    state_next = gfd_pkg::ST_RATE_LO;
                end
            end
            gfd_pkg::ST_HDR0:     state_next = is_ff ? gfd_pkg::ST_HDR1 : gfd_pkg::ST_HUNT;
            gfd_pkg::ST_HDR1:     state_next = is_ff ? gfd_pkg::ST_RATE_LO : gfd_pkg::ST_HUNT;
            gfd_pkg::ST_RATE_LO:  state_next = gfd_pkg::ST_RATE_HI;
            gfd_pkg::ST_RATE_HI:  state_next = gfd_pkg::ST_ANGLE_LO;
            gfd_pkg::ST_ANGLE_LO: state_next = gfd_pkg::ST_ANGLE_HI;
            gfd_pkg::ST_ANGLE_HI: state_next = gfd_pkg::ST_SUM_LO;
            gfd_pkg::ST_SUM_LO:   state_next = gfd_pkg::ST_SUM_HI;
            gfd_pkg::ST_SUM_HI:   state_next = gfd_pkg::ST_HDR0;
            default:              state_next = gfd_pkg::ST_HUNT;
        endcase
    end

    // Result for the current byte: header error or finished frame
    always_comb
    begin
        emit                = 1'b0;
        result.turn_rate    = '0;
        result.heading      = '0;
        result.frame_status = gfd_pkg::STATUS_GOOD;
        unique case (state_reg)
            gfd_pkg::ST_HDR0, gfd_pkg::ST_HDR1:
            begin
                emit                = !is_ff;
                result.frame_status = gfd_pkg::STATUS_HDR_ERR;
            end
            gfd_pkg::ST_SUM_HI:
            begin
                emit                = 1'b1;
                result.turn_rate    = rate_reg;
                result.heading      = angle_reg;
                result.frame_status = (sum_expect == sum_got) ? gfd_pkg::STATUS_GOOD
                                                              : gfd_pkg::STATUS_SUM_ERR;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Advance framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gfd_pkg::ST_HUNT;
            prev_ff_reg <= 1'b0;
            rate_reg    <= '0;
            angle_reg   <= '0;
            sum_lo_reg  <= '0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            prev_ff_reg <= prev_ff_next;
            unique case (state_reg)
                gfd_pkg::ST_RATE_LO:  rate_reg[7:0]   <= rx_byte;
                gfd_pkg::ST_RATE_HI:  rate_reg[15:8]  <= rx_byte;
                gfd_pkg::ST_ANGLE_LO: angle_reg[7:0]  <= rx_byte;
                gfd_pkg::ST_ANGLE_HI: angle_reg[15:8] <= rx_byte;
                gfd_pkg::ST_SUM_LO:   sum_lo_reg      <= rx_byte;
                default:
                begin
                    sum_lo_reg <= sum_lo_reg;
                end
            endcase
        end
    end

endmodule

[design/gyro_frame_deframer.sv]
// Gyro frame deframer.
// rx (sink): one received serial byte per transfer, valid/ready handshake.
// frames (source): one transfer per finished frame or header error, carrying
// turn_rate, heading and frame_status (good, checksum error, header missing).
// Frames are FF FF, rate lo/hi, angle lo/hi, checksum lo/hi; the checksum is
// 0xFFFF + rate + angle, modulo 2^16. After a frame the next header must
// follow at once; a non-0xFF header byte gives a header-error result with
// zero words and drops back to hunting.
// The transfer of the byte that completes a result loads the input register;
// the decode of that byte then loads the result register, which drives
// frames. Throughput: one byte per cycle unless a stalled result holds it;
// the decode step is one register-to-register pass through the framing
// state and a 16-bit add of three terms and a compare.
// Reset: hunting for a header, both internal stages empty.
// Stalls: while frames.ready is low the held result stays; bytes that give no
// result keep flowing, and only a byte that would give a second result waits
// in the input register, which then holds rx.ready low.
module gyro_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    gfd_byte_if.sink      rx,
    gfd_result_if.source  frames
);

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg;
    gfd_pkg::result_t out_data_reg;

    logic             emit;
    gfd_pkg::result_t result;
    logic             out_free;
    logic             s1_go;

    gfd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_go),
        .rx_byte (s1_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    assign out_free = !out_valid_reg || frames.ready;
    assign s1_go    = s1_valid_reg && (!emit || out_free);
    assign rx.ready = !s1_valid_reg || s1_go;

    // Input register: load on transfer, drop once decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    // Result register: hold until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frames.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign frames.valid        = out_valid_reg;
    assign frames.turn_rate    = out_data_reg.turn_rate;
    assign frames.heading      = out_data_reg.heading;
    assign frames.frame_status = out_data_reg.frame_status;

    // A header error never carries data words
    a_hdr_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_status == gfd_pkg::STATUS_HDR_ERR)
        |-> (out_data_reg.turn_rate == 16'sd0 && out_data_reg.heading == 16'sd0))
        else $error("header error result carries nonzero words");

    // Status code three is never produced
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.frame_status == gfd_pkg::STATUS_GOOD ||
                           out_data_reg.frame_status == gfd_pkg::STATUS_SUM_ERR ||
                           out_data_reg.frame_status == gfd_pkg::STATUS_HDR_ERR))
        else $error("invalid frame status");

    // A byte that would overwrite a stalled result waits in the input register
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && emit && out_valid_reg && !frames.ready)
        |=> (s1_valid_reg && $stable(s1_byte_reg) && out_valid_reg))
        else $error("pending byte lost while result stalled");

    // No new byte is taken while the input register is blocked
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |-> !rx.ready)
        else $error("byte accepted into a blocked input register");

endmodule
